FILE: rtl/sliding_median_filter_macros.svh
// Assertion macros for the sliding median filter.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SLIDING_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smf: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define SMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smf: next-cycle check failed");

`endif

FILE: rtl/smf_pkg.sv
// Shared constants and types for the sliding median filter.
// No dependencies; the modules, interfaces and testbench refer to it by scoped names.
package smf_pkg;

  localparam int WINDOW      = 11;
  localparam int SAMPLE_BITS = 16;
  localparam int HALF        = (WINDOW - 1) / 2;
  localparam int FILL_MAX    = WINDOW + HALF;
  localparam int RANK_W      = 4;
  localparam int RANK_RESET  = HALF;

  // fill counter, window position and rank count widths
  localparam int CNT_W  = $clog2(FILL_MAX + 1);
  localparam int POS_W  = $clog2(WINDOW);
  localparam int RCNT_W = $clog2(WINDOW + 1);
  localparam int CMP_W  = (RANK_W > RCNT_W) ? RANK_W : RCNT_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [WINDOW-1:0] window_t;

  // Work left over for the output side after one transaction
  typedef struct packed {
    logic             main;   // one centred result still to go
    logic             filt;   // that result is the ranked value
    logic             flush;  // tail of the trace still to go
    logic [POS_W-1:0] pos;    // next window entry of the tail
  } job_t;

endpackage

FILE: rtl/smf_if.sv
// Valid/ready channel interfaces for the sliding median filter.
// Depends on smf_pkg for the sample type.
interface smf_in_if;
  logic            valid;
  logic            ready;
  smf_pkg::sample_t sample;
  logic            last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface smf_out_if;
  logic            valid;
  logic            ready;
  smf_pkg::sample_t out_sample;
  logic            out_last;

  modport source (output valid, output out_sample, output out_last, input ready);
  modport sink (input valid, input out_sample, input out_last, output ready);
endinterface

FILE: rtl/smf_window.sv
// Sample window shift register and trace fill counter.
// Depends on smf_pkg; builds the job descriptor for each accepted sample.
module smf_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  smf_pkg::sample_t  sample_i,
  input  logic              last_i,
  output smf_pkg::window_t  window_o,
  output smf_pkg::job_t     job_o
);

  smf_pkg::window_t               window_q, window_d;
  logic [smf_pkg::CNT_W-1:0]      fill_q, fill_d;

  // Shift in the new sample, entry 0 the oldest
  always_comb begin
    for (int k = 0; k < smf_pkg::WINDOW - 1; k++) begin
      window_d[k] = window_q[k + 1];
    end
    window_d[smf_pkg::WINDOW-1] = sample_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      window_q <= window_d;
    end
  end

  // Fill count saturates, and restarts after the last sample of a trace
  always_comb begin
    fill_d = fill_q;
    if (accept_i) begin
      if (last_i) begin
        fill_d = '0;
      end else if (fill_q < smf_pkg::CNT_W'(smf_pkg::FILL_MAX)) begin
        fill_d = fill_q + smf_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Job for this sample, judged by its index within the trace
  always_comb begin
    job_o.main  = fill_q >= smf_pkg::CNT_W'(smf_pkg::HALF);
    job_o.filt  = fill_q >= smf_pkg::CNT_W'(smf_pkg::FILL_MAX);
    job_o.flush = last_i;
    // tail starts at WINDOW - min(index + 1, HALF)
    if (fill_q < smf_pkg::CNT_W'(smf_pkg::HALF)) begin
      job_o.pos = smf_pkg::POS_W'(smf_pkg::WINDOW - 1) - smf_pkg::POS_W'(fill_q);
    end else begin
      job_o.pos = smf_pkg::POS_W'(smf_pkg::WINDOW - smf_pkg::HALF);
    end
  end

  assign window_o = window_q;

endmodule

FILE: rtl/smf_rank.sv
// Rank selection over the sample window by parallel rank counting.
// Depends on smf_pkg; purely combinational.
module smf_rank (
  input  smf_pkg::window_t             window_i,
  input  logic [smf_pkg::RANK_W-1:0]   rank_i,
  output smf_pkg::sample_t             value_o
);

  logic [smf_pkg::CMP_W-1:0] rank_c;
  smf_pkg::sample_t          masked [smf_pkg::WINDOW];

  // Out-of-range ranks pick the largest entry
  always_comb begin
    if (smf_pkg::CMP_W'(rank_i) >= smf_pkg::CMP_W'(smf_pkg::WINDOW)) begin
      rank_c = smf_pkg::CMP_W'(smf_pkg::WINDOW - 1);
    end else begin
      rank_c = smf_pkg::CMP_W'(rank_i);
    end
  end

  // Each entry counts how many lie below it and up to it
  for (genvar k = 0; k < smf_pkg::WINDOW; k++) begin : g_cand
    logic [smf_pkg::WINDOW-1:0]  lt;
    logic [smf_pkg::WINDOW-1:0]  le;
    logic [smf_pkg::RCNT_W-1:0]  below;
    logic [smf_pkg::RCNT_W-1:0]  upto;
    logic                        hit;

    for (genvar m = 0; m < smf_pkg::WINDOW; m++) begin : g_cmp
      assign lt[m] = $signed(window_i[m]) <  $signed(window_i[k]);
      assign le[m] = $signed(window_i[m]) <= $signed(window_i[k]);
    end

    assign below = smf_pkg::RCNT_W'($countones(lt));
    assign upto  = smf_pkg::RCNT_W'($countones(le));
    assign hit   = (smf_pkg::CMP_W'(below) <= rank_c) && (rank_c < smf_pkg::CMP_W'(upto));
    assign masked[k] = hit ? window_i[k] : '0;
  end

  // All hits carry the same value, so an OR merges them
  always_comb begin
    value_o = '0;
    for (int k = 0; k < smf_pkg::WINDOW; k++) begin
      value_o = value_o | masked[k];
    end
  end

endmodule

FILE: rtl/smf_emit.sv
// Job register and output register; sequences the results of a transaction.
// Depends on smf_pkg, smf_if and the assertion macros.
`include "sliding_median_filter_macros.svh"

module smf_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  smf_pkg::job_t     job_i,
  input  smf_pkg::window_t  window_i,
  input  smf_pkg::sample_t  ranked_i,
  output logic              in_ready_o,
  smf_out_if.source         out_o
);

  logic             job_valid_q, job_valid_d;
  smf_pkg::job_t    job_q, job_d;
  logic             out_valid_q, out_valid_d;
  smf_pkg::sample_t out_sample_q;
  logic             out_last_q;

  smf_pkg::sample_t beat_sample;
  logic             beat_last;
  logic             beat_end;
  logic             load;

  // Current beat: centred result first, then the tail of the trace
  always_comb begin
    if (job_q.main) begin
      beat_sample = job_q.filt ? ranked_i : window_i[smf_pkg::WINDOW-1-smf_pkg::HALF];
      beat_last   = 1'b0;
      beat_end    = !job_q.flush;
    end else begin
      beat_sample = window_i[job_q.pos];
      beat_last   = job_q.pos == smf_pkg::POS_W'(smf_pkg::WINDOW - 1);
      beat_end    = beat_last;
    end
  end

  assign load       = job_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready_o = !job_valid_q || (load && beat_end);

  // Job advance
  always_comb begin
    job_valid_d = job_valid_q;
    job_d       = job_q;
    if (accept_i) begin
      job_valid_d = job_i.main || job_i.flush;
      job_d       = job_i;
    end else if (load) begin
      if (beat_end) begin
        job_valid_d = 1'b0;
      end else if (job_q.main) begin
        job_d.main = 1'b0;
      end else begin
        job_d.pos = job_q.pos + smf_pkg::POS_W'(1);
      end
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (load) begin
      out_sample_q <= beat_sample;
      out_last_q   <= beat_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_sample_q;
  assign out_o.out_last   = out_last_q;

  // A job without its centred result must be working through a tail
  `SMF_ASSERT_NOW(a_tail_only, job_valid_q && !job_q.main, job_q.flush)
  // Tail position stays inside the newest HALF entries
  `SMF_ASSERT_NOW(a_tail_pos, job_valid_q && !job_q.main,
                  job_q.pos >= smf_pkg::POS_W'(smf_pkg::WINDOW - smf_pkg::HALF))
  // An unfinished job is still there after a beat leaves
  `SMF_ASSERT_NEXT(a_job_holds, load && !beat_end && !accept_i, job_valid_q)

endmodule

FILE: rtl/sliding_median_filter.sv
// Top level of the sliding median filter: channels, rank register, wiring.
// Depends on smf_pkg, smf_if, smf_window, smf_rank and smf_emit.
//
// Usage:
//   in_i carries one signed sample per transaction plus a last flag that
//   closes a trace. out_o carries filtered samples, each five samples
//   behind its input, and out_last on the final result of a trace.
//   cfg_we_i / cfg_wdata_i write the rank register (0 = smallest, reset
//   value 5 = true median; values of 11 and above pick the largest).
//   Write it only while the block is idle.
// Timing:
//   A sample is accepted every cycle unless stalled. Its result goes via
//   the job register to the output register. A last sample releases up
//   to six results, one per cycle while the receiver is ready; the input
//   stalls until the last is loaded. The rank is found by counting, for
//   all 11 window entries at once, the entries below and up to each one.
// Reset and stalls:
//   Reset clears the fill count, the pending job and the output valid.
//   When the receiver holds off, the output register keeps its result,
//   one further job waits in the job register, then the input stalls.
module sliding_median_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [smf_pkg::RANK_W-1:0] cfg_wdata_i,
  smf_in_if.sink                     in_i,
  smf_out_if.source                  out_o
);

  logic [smf_pkg::RANK_W-1:0] rank_q;
  logic                       accept;
  logic                       in_ready;
  smf_pkg::window_t           window;
  smf_pkg::job_t              job;
  smf_pkg::sample_t           ranked;

  // Rank register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= smf_pkg::RANK_W'(smf_pkg::RANK_RESET);
    end else if (cfg_we_i) begin
      rank_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  smf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (in_i.sample),
    .last_i   (in_i.last),
    .window_o (window),
    .job_o    (job)
  );

  smf_rank u_rank (
    .window_i (window),
    .rank_i   (rank_q),
    .value_o  (ranked)
  );

  smf_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .job_i      (job),
    .window_i   (window),
    .ranked_i   (ranked),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

endmodule

FILE: test/sliding_median_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_median_filter: traces of signed samples
// through the 11-tap rank filter, checked against a predictor kept here.
// Depends on smf_pkg and the smf_in_if / smf_out_if channel interfaces.
module sliding_median_filter_tb;

  localparam int  SETTLE_CYCLES = 8;     // cycles allowed after the last result
  localparam int  HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int  PHASE_ITEMS   = 20;    // minimum samples per rank setting
  localparam time RUN_LIMIT     = 12_000_000;

  typedef struct packed {
    smf_pkg::sample_t value;
    logic             last;
  } filt_out_t;

  logic clk_i;
  logic rst_ni;
  logic                       cfg_we_i;
  logic [smf_pkg::RANK_W-1:0] cfg_wdata_i;

  smf_in_if  in_ch ();
  smf_out_if out_ch ();

  sliding_median_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Predictor state: window (entry 0 oldest), trace position, rank register
  smf_pkg::sample_t           win_q [smf_pkg::WINDOW];
  int unsigned                trace_pos;
  logic [smf_pkg::RANK_W-1:0] rank_q;
  filt_out_t                  trace_out_q [$];

  // Run control and bookkeeping
  bit src_idle_en;
  bit sink_idle_en;
  bit hold_req;
  int mismatches;
  int samples_in;
  int results_out;
  int traces_sent;
  int filtered_out;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Value of the given rank within the current window, ties ranked by value
  function automatic smf_pkg::sample_t window_rank(int unsigned r);
    int unsigned below;
    int unsigned upto;
    for (int k = 0; k < smf_pkg::WINDOW; k++) begin
      below = 0;
      upto  = 0;
      for (int m = 0; m < smf_pkg::WINDOW; m++) begin
        if (win_q[m] < win_q[k]) below++;
        if (win_q[m] <= win_q[k]) upto++;
      end
      if (below <= r && r < upto) return win_q[k];
    end
    return win_q[smf_pkg::WINDOW-1];
  endfunction

  // Shift one sample into the window and queue the results it releases
  function automatic void advance_window(smf_pkg::sample_t s, logic lst);
    int unsigned r;
    int unsigned pend;
    filt_out_t   res;
    for (int k = 0; k < smf_pkg::WINDOW - 1; k++) win_q[k] = win_q[k+1];
    win_q[smf_pkg::WINDOW-1] = s;
    r = (rank_q >= smf_pkg::WINDOW) ? smf_pkg::WINDOW - 1 : rank_q;
    // centred result, ranked once the window is past the trace head
    if (trace_pos >= smf_pkg::HALF) begin
      if (trace_pos >= smf_pkg::FILL_MAX) begin
        res.value = window_rank(r);
        filtered_out++;
      end else begin
        res.value = win_q[smf_pkg::WINDOW-1-smf_pkg::HALF];
      end
      res.last = 1'b0;
      trace_out_q.push_back(res);
    end
    // flush of the trace tail, raw
    if (lst) begin
      pend = (trace_pos + 1 < smf_pkg::HALF) ? trace_pos + 1 : smf_pkg::HALF;
      for (int unsigned j = 0; j < pend; j++) begin
        res.value = win_q[smf_pkg::WINDOW-pend+j];
        res.last  = (j + 1 == pend);
        trace_out_q.push_back(res);
      end
      trace_pos = 0;
    end else if (trace_pos < smf_pkg::FILL_MAX) begin
      trace_pos++;
    end
  endfunction

  // Check each output transaction, then account for each input transaction
  always @(posedge clk_i) begin
    filt_out_t exp_res;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        results_out++;
        if (trace_out_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual sample %0d last %0b",
                   $time, out_ch.out_sample, out_ch.out_last);
          mismatches++;
        end else begin
          exp_res = trace_out_q.pop_front();
          if (out_ch.out_sample !== exp_res.value) begin
            $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                     $time, exp_res.value, out_ch.out_sample);
            mismatches++;
          end
          if (out_ch.out_last !== exp_res.last) begin
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, exp_res.last, out_ch.out_last);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        samples_in++;
        advance_window(in_ch.sample, in_ch.last);
      end
    end
  end

  // Receiver: random ready bursts, plus a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Offer one sample and wait for its transaction; valid stays high afterwards
  task automatic send_sample(smf_pkg::sample_t s, logic lst);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.last   <= lst;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    if (lst) traces_sent++;
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    // the loop waits on the clock before its first check, so the last accepted sample is already predicted
    do @(posedge clk_i); while (trace_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rank(logic [smf_pkg::RANK_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    rank_q = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Extremes, small values that often repeat, and full-range random values
  function automatic smf_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return smf_pkg::sample_t'(16'sh7fff);
      1:       return smf_pkg::sample_t'(16'sh8000);
      2, 3, 4: return smf_pkg::sample_t'($signed($urandom_range(0, 6)) - 3);
      default: return smf_pkg::sample_t'($urandom);
    endcase
  endfunction

  // One trace of random content; mostly long enough to reach the ranked part
  task automatic send_trace(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_sample(pick_sample(), i + 1 == len);
  endtask

  function automatic int unsigned pick_len();
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, smf_pkg::FILL_MAX);
    return $urandom_range(smf_pkg::FILL_MAX + 1, 40);
  endfunction

  // Short traces at the reset rank: single sample, six-result flush, first ranked output
  task automatic test_trace_edges();
    smf_pkg::sample_t six [6];
    smf_pkg::sample_t longer [17];
    six    = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh7fff};
    longer = '{16'sh8000, 16'sh7fff, 16'sd4, 16'sd4, 16'sd4, -16'sd1, 16'sh0000,
               16'sh7fff, 16'sh8000, 16'sd4, -16'sd2, 16'sh7fff, 16'sh8000,
               16'sd3, 16'sd4, 16'sh5555, -16'sh5556};
    send_sample(16'sh8000, 1'b1);
    foreach (six[i]) send_sample(six[i], i == 5);
    foreach (longer[i]) send_sample(longer[i], i == 16);
    wait_idle();
  endtask

  // Six rank settings: the extremes, two out-of-range values, a random one and the reset rank
  task automatic test_rank_sweep();
    logic [smf_pkg::RANK_W-1:0] ranks [6];
    int start;
    ranks = '{4'd0, 4'd10, 4'd11, 4'd15, smf_pkg::RANK_W'($urandom_range(1, 9)),
              smf_pkg::RANK_W'(smf_pkg::RANK_RESET)};
    foreach (ranks[i]) begin
      write_rank(ranks[i]);
      start = samples_in;
      while (samples_in - start < PHASE_ITEMS) send_trace(pick_len());
      wait_idle();
    end
  endtask

  // Receiver holds off while samples keep coming, so the input must stall
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_trace(40);
    wait_idle();
  endtask

  // Random traces, the closing part without any idling
  task automatic test_random_traces();
    int start;
    write_rank(smf_pkg::RANK_W'($urandom_range(0, 15)));
    start = samples_in;
    while (samples_in - start < 40) send_trace(pick_len());
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    start = samples_in;
    while (samples_in - start < 35) send_trace(pick_len());
    wait_idle();
  endtask

  // Main sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last   <= 1'b0;
    foreach (win_q[k]) win_q[k] = '0;
    trace_pos    = 0;
    rank_q       = smf_pkg::RANK_W'(smf_pkg::RANK_RESET);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    hold_req     = 1'b0;
    mismatches   = 0;
    samples_in   = 0;
    results_out  = 0;
    traces_sent  = 0;
    filtered_out = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_trace_edges();
    test_rank_sweep();
    test_backpressure();
    test_random_traces();

    $display("Run covered %0d samples in %0d traces, %0d results (%0d ranked),",
             samples_in, traces_sent, results_out, filtered_out);
    $display("ranks 0, 10, 11, 15 and others, random stalls and a long output hold-off");
    if (mismatches == 0) begin
      $display("PASS sliding_median_filter");
    end else begin
      $display("FAIL sliding_median_filter");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("FAIL sliding_median_filter");
    $finish;
  end

endmodule

FILE: sliding_median_filter.f
+incdir+rtl
rtl/smf_pkg.sv
rtl/smf_if.sv
rtl/smf_window.sv
rtl/smf_rank.sv
rtl/smf_emit.sv
rtl/sliding_median_filter.sv
test/sliding_median_filter_tb.sv
